### design/dssp_pkg.sv
// ----------------------------------------------------------------------------
// dssp_pkg
// Types and constants shared by the dual servo slew positioner modules.
// ----------------------------------------------------------------------------
package dssp_pkg;

	// request modes
	localparam logic MODE_TICK = 1'b0;
	localparam logic MODE_MOVE = 1'b1;

	// field widths
	localparam int GOAL_W    = 18;
	localparam int FRAC_W    = 17;
	localparam int OFFSET_W  = 11;
	localparam int WAIT_W    = 10;
	localparam int POS_W     = 15;
	localparam int REM_W     = 16;
	localparam int COMPARE_W = 12;
	localparam int PHASE_W   = 2;
	localparam int PROD_W    = 30;

	// fixed values
	localparam logic [GOAL_W-1:0]   FRAC_ONE        = 18'd65536;
	localparam int                  BASE_PULSE_US   = 700;
	localparam logic [POS_W-1:0]    CENTER_POS      = 15'd15000;
	localparam logic [OFFSET_W-1:0] MIN_OFFSET_RST  = 11'd0;
	localparam logic [OFFSET_W-1:0] MAX_OFFSET_RST  = 11'd1600;
	localparam logic [WAIT_W-1:0]   WAIT_TICKS_RST  = 10'd150;

	// queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = 2;
	localparam int QUEUE_CNT_W = 3;

	// configuration register map
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;
	localparam logic [2:0] REG_X_MIN       = 3'd0;
	localparam logic [2:0] REG_X_MAX       = 3'd1;
	localparam logic [2:0] REG_Y_MIN       = 3'd2;
	localparam logic [2:0] REG_Y_MAX       = 3'd3;
	localparam logic [2:0] REG_CENTER_WAIT = 3'd4;
	localparam logic [2:0] REG_SETTLE_WAIT = 3'd5;

	// phase codes as reported on the result channel
	localparam logic [PHASE_W-1:0] PHASE_CODE_CENTER = 2'd0;
	localparam logic [PHASE_W-1:0] PHASE_CODE_IDLE   = 2'd1;
	localparam logic [PHASE_W-1:0] PHASE_CODE_MOVING = 2'd2;

	typedef enum logic [2:0] {
		PH_CENTER = 3'b001,
		PH_IDLE   = 3'b010,
		PH_MOVING = 3'b100
	} phase_t;

	typedef struct packed {
		logic [OFFSET_W-1:0] x_min;
		logic [OFFSET_W-1:0] x_max;
		logic [OFFSET_W-1:0] y_min;
		logic [OFFSET_W-1:0] y_max;
	} map_cfg_t;

	typedef struct packed {
		logic             mode;
		logic [POS_W-1:0] target_x;
		logic [POS_W-1:0] target_y;
	} item_t;

	function automatic logic [PHASE_W-1:0] phase_code(input phase_t ph);
		logic [PHASE_W-1:0] code;
		unique case (ph)
			PH_CENTER: code = PHASE_CODE_CENTER;
			PH_IDLE:   code = PHASE_CODE_IDLE;
			PH_MOVING: code = PHASE_CODE_MOVING;
			default:   code = PHASE_CODE_CENTER;
		endcase
		return code;
	endfunction

	// exact floor(p / 10) for any 15-bit p
	function automatic logic [COMPARE_W-1:0] div10(input logic [POS_W-1:0] p);
		logic [30:0] prod;
		prod = 31'(p) * 31'd52429;
		return prod[30:19];
	endfunction

endpackage

### design/dssp_ifs.sv
// ----------------------------------------------------------------------------
// dssp_ifs
// Valid/ready channel interfaces for move/tick requests and results.
// ----------------------------------------------------------------------------
interface dssp_cmd_if;
	logic                              valid;
	logic                              ready;
	logic                              mode;
	logic signed [dssp_pkg::GOAL_W-1:0] goal_x;
	logic signed [dssp_pkg::GOAL_W-1:0] goal_y;

	modport source (output valid, output mode, output goal_x, output goal_y, input ready);
	modport sink (input valid, input mode, input goal_x, input goal_y, output ready);
endinterface

interface dssp_rsp_if;
	logic                               valid;
	logic                               ready;
	logic [dssp_pkg::COMPARE_W-1:0]     compare_x;
	logic [dssp_pkg::COMPARE_W-1:0]     compare_y;
	logic                               motion_done;
	logic                               settled;
	logic [dssp_pkg::PHASE_W-1:0]       phase;

	modport source (output valid, output compare_x, output compare_y, output motion_done,
		output settled, output phase, input ready);
	modport sink (input valid, input compare_x, input compare_y, input motion_done,
		input settled, input phase, output ready);
endinterface

### design/dssp_front.sv
// ----------------------------------------------------------------------------
// dssp_front
// Accepts requests and maps move goals to pulse-width targets.
// ----------------------------------------------------------------------------
module dssp_front (
	input  logic                            clk,
	input  logic                            arst_n,
	dssp_cmd_if.sink                        cmd,
	input  dssp_pkg::map_cfg_t              cfg,
	input  logic [dssp_pkg::QUEUE_CNT_W-1:0] queue_count,
	output logic                            push,
	output dssp_pkg::item_t                 push_item
);

	localparam int SUM_W = 31;
	localparam int TOT_W = 35;
	localparam int BASE_W = 12;

	logic                                valid_s1;
	logic                                mode_s1;
	logic signed [dssp_pkg::PROD_W-1:0]  prod_x_s1;
	logic signed [dssp_pkg::PROD_W-1:0]  prod_y_s1;

	logic [dssp_pkg::QUEUE_CNT_W-1:0]    in_flight;
	logic                                accept;
	logic [dssp_pkg::FRAC_W-1:0]         frac_x;
	logic [dssp_pkg::FRAC_W-1:0]         frac_y;
	logic signed [BASE_W-1:0]            span_x;
	logic signed [BASE_W-1:0]            span_y;
	logic [BASE_W-1:0]                   base_x;
	logic [BASE_W-1:0]                   base_y;

	function automatic logic [dssp_pkg::FRAC_W-1:0] clamp_goal(
		input logic signed [dssp_pkg::GOAL_W-1:0] g
	);
		logic [dssp_pkg::FRAC_W-1:0] v;
		if (g[dssp_pkg::GOAL_W-1]) begin
			v = '0;
		end else if (g > $signed(dssp_pkg::FRAC_ONE)) begin
			v = dssp_pkg::FRAC_ONE[dssp_pkg::FRAC_W-1:0];
		end else begin
			v = g[dssp_pkg::FRAC_W-1:0];
		end
		return v;
	endfunction

	// target = floor(10 * (base * 2^16 + prod) / 2^16), negative clamps to zero
	function automatic logic [dssp_pkg::POS_W-1:0] finish_target(
		input logic [BASE_W-1:0] base,
		input logic signed [dssp_pkg::PROD_W-1:0] prod
	);
		logic signed [SUM_W-1:0] sum;
		logic signed [TOT_W-1:0] tot;
		logic [dssp_pkg::POS_W-1:0] t;
		sum = $signed({3'b000, base, 16'h0000}) + SUM_W'(prod);
		tot = (TOT_W'(sum) <<< 3) + (TOT_W'(sum) <<< 1);
		if (tot[TOT_W-1]) begin
			t = '0;
		end else begin
			t = tot[30:16];
		end
		return t;
	endfunction

	function automatic logic signed [dssp_pkg::PROD_W-1:0] PROD_W_cast_x(
		input logic [dssp_pkg::FRAC_W-1:0] v,
		input logic signed [BASE_W-1:0] span
	);
		logic signed [dssp_pkg::PROD_W-1:0] p;
		p = dssp_pkg::PROD_W'($signed({1'b0, v})) * dssp_pkg::PROD_W'(span);
		return p;
	endfunction

	assign in_flight = queue_count + dssp_pkg::QUEUE_CNT_W'(valid_s1);
	assign cmd.ready = in_flight < dssp_pkg::QUEUE_CNT_W'(dssp_pkg::QUEUE_DEPTH);
	assign accept    = cmd.valid && cmd.ready;

	assign frac_x = clamp_goal(cmd.goal_x);
	assign frac_y = clamp_goal(cmd.goal_y);
	assign span_x = $signed({1'b0, cfg.x_max}) - $signed({1'b0, cfg.x_min});
	assign span_y = $signed({1'b0, cfg.y_max}) - $signed({1'b0, cfg.y_min});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1   <= cmd.mode;
			prod_x_s1 <= PROD_W_cast_x(frac_x, span_x);
			prod_y_s1 <= PROD_W_cast_x(frac_y, span_y);
		end
	end

	assign base_x = BASE_W'(dssp_pkg::BASE_PULSE_US) + BASE_W'(cfg.x_min);
	assign base_y = BASE_W'(dssp_pkg::BASE_PULSE_US) + BASE_W'(cfg.y_min);

	assign push               = valid_s1;
	assign push_item.mode     = mode_s1;
	assign push_item.target_x = finish_target(base_x, prod_x_s1);
	assign push_item.target_y = finish_target(base_y, prod_y_s1);

endmodule

### design/dssp_queue.sv
// ----------------------------------------------------------------------------
// dssp_queue
// Short request queue between the front and back parts.
// ----------------------------------------------------------------------------
module dssp_queue (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	input  dssp_pkg::item_t                  push_item,
	input  logic                             pop,
	output logic                             head_valid,
	output dssp_pkg::item_t                  head_item,
	output logic [dssp_pkg::QUEUE_CNT_W-1:0] count
);

	dssp_pkg::item_t                   entries [dssp_pkg::QUEUE_DEPTH];
	logic [dssp_pkg::QUEUE_PTR_W-1:0]  wr_ptr_q;
	logic [dssp_pkg::QUEUE_PTR_W-1:0]  rd_ptr_q;
	logic [dssp_pkg::QUEUE_CNT_W-1:0]  count_q;

	assign head_valid = count_q != '0;
	assign head_item  = entries[rd_ptr_q];
	assign count      = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries[wr_ptr_q] <= push_item;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |-> (count_q < dssp_pkg::QUEUE_CNT_W'(dssp_pkg::QUEUE_DEPTH)))
		else $error("request queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("pop from empty request queue");

endmodule

### design/dssp_back.sv
// ----------------------------------------------------------------------------
// dssp_back
// Applies moves and ticks to the axis state and registers the result.
// ----------------------------------------------------------------------------
module dssp_back #(
	parameter int STEP_LIMIT = 30
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          head_valid,
	input  dssp_pkg::item_t               head_item,
	input  logic [dssp_pkg::WAIT_W-1:0]   settle_wait_ticks,
	output logic                          pop,
	dssp_rsp_if.source                    rsp
);

	localparam logic signed [dssp_pkg::REM_W-1:0] LIM = dssp_pkg::REM_W'(STEP_LIMIT);

	logic [dssp_pkg::POS_W-1:0]          pos_x_q, pos_y_q, pos_x_n, pos_y_n;
	logic signed [dssp_pkg::REM_W-1:0]   rem_x_q, rem_y_q, rem_x_n, rem_y_n;
	logic signed [dssp_pkg::REM_W-1:0]   step_x, step_y;
	dssp_pkg::phase_t                    phase_q, phase_n;
	logic [dssp_pkg::WAIT_W-1:0]         wait_cnt_q, wait_cnt_n;
	logic                                wait_armed_q, wait_armed_n;
	logic                                done_n, settled_n;
	logic                                out_valid_q;

	function automatic logic signed [dssp_pkg::REM_W-1:0] limit_step(
		input logic signed [dssp_pkg::REM_W-1:0] r
	);
		logic signed [dssp_pkg::REM_W-1:0] s;
		if (r > LIM) begin
			s = LIM;
		end else if (r < -LIM) begin
			s = -LIM;
		end else begin
			s = r;
		end
		return s;
	endfunction

	assign pop = head_valid && (!out_valid_q || rsp.ready);

	assign step_x = limit_step(rem_x_q);
	assign step_y = limit_step(rem_y_q);

	always_comb begin
		pos_x_n      = pos_x_q;
		pos_y_n      = pos_y_q;
		rem_x_n      = rem_x_q;
		rem_y_n      = rem_y_q;
		phase_n      = phase_q;
		wait_cnt_n   = wait_cnt_q;
		wait_armed_n = wait_armed_q;
		done_n       = 1'b0;
		settled_n    = 1'b0;
		if (head_item.mode == dssp_pkg::MODE_MOVE) begin
			rem_x_n = $signed({1'b0, head_item.target_x}) - $signed({1'b0, pos_x_q});
			rem_y_n = $signed({1'b0, head_item.target_y}) - $signed({1'b0, pos_y_q});
			// centering keeps its phase and timer
			unique case (phase_q)
				dssp_pkg::PH_IDLE:   phase_n = dssp_pkg::PH_MOVING;
				dssp_pkg::PH_MOVING: wait_armed_n = 1'b0;
				default: ;
			endcase
		end else begin
			// timer is served before the axes move
			if (wait_armed_q) begin
				if (wait_cnt_q <= dssp_pkg::WAIT_W'(1)) begin
					wait_armed_n = 1'b0;
					wait_cnt_n   = '0;
					settled_n    = phase_q == dssp_pkg::PH_MOVING;
					phase_n      = dssp_pkg::PH_IDLE;
				end else begin
					wait_cnt_n = wait_cnt_q - 1'b1;
				end
			end
			rem_x_n = rem_x_q - step_x;
			rem_y_n = rem_y_q - step_y;
			pos_x_n = dssp_pkg::POS_W'($signed({1'b0, pos_x_q}) + step_x);
			pos_y_n = dssp_pkg::POS_W'($signed({1'b0, pos_y_q}) + step_y);
			if ((rem_x_q != '0 || rem_y_q != '0) && rem_x_n == '0 && rem_y_n == '0) begin
				done_n = 1'b1;
				if (phase_n == dssp_pkg::PH_MOVING) begin
					wait_cnt_n   = settle_wait_ticks;
					wait_armed_n = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q      <= dssp_pkg::CENTER_POS;
			pos_y_q      <= dssp_pkg::CENTER_POS;
			rem_x_q      <= '0;
			rem_y_q      <= '0;
			phase_q      <= dssp_pkg::PH_CENTER;
			wait_cnt_q   <= dssp_pkg::WAIT_TICKS_RST;
			wait_armed_q <= 1'b1;
			out_valid_q  <= 1'b0;
		end else begin
			if (pop) begin
				pos_x_q      <= pos_x_n;
				pos_y_q      <= pos_y_n;
				rem_x_q      <= rem_x_n;
				rem_y_q      <= rem_y_n;
				phase_q      <= phase_n;
				wait_cnt_q   <= wait_cnt_n;
				wait_armed_q <= wait_armed_n;
				out_valid_q  <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rsp.compare_x   <= dssp_pkg::div10(pos_x_n);
			rsp.compare_y   <= dssp_pkg::div10(pos_y_n);
			rsp.motion_done <= done_n;
			rsp.settled     <= settled_n;
			rsp.phase       <= dssp_pkg::phase_code(phase_n);
		end
	end

	assign rsp.valid = out_valid_q;

	a_center_armed: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == dssp_pkg::PH_CENTER) |-> wait_armed_q)
		else $error("centering phase without running timer");

	a_idle_disarmed: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == dssp_pkg::PH_IDLE) |-> !wait_armed_q)
		else $error("timer running in idle phase");

	a_settled_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && settled_n) |=> (rsp.phase == dssp_pkg::PHASE_CODE_IDLE))
		else $error("settled report outside idle phase");

endmodule

### design/dual_servo_slew_positioner.sv
// ----------------------------------------------------------------------------
// dual_servo_slew_positioner
// Two-axis servo positioner with rate-limited slewing and PWM compare output.
// ----------------------------------------------------------------------------
// Takes one request per clock cycle while results are taken, and returns one
// result per request, in order. A request passes through the goal mapping
// register (one multiply per axis), a four-entry queue, and the axis state
// update, whose result is held in the output register. The state update in
// the back part sets the sustained rate of one request per cycle while results
// are taken; when results stall, five requests are held (four between the
// mapping register and the queue, one in the output register) before the input
// stops accepting.
module dual_servo_slew_positioner #(
	parameter int STEP_LIMIT = 30
) (
	input  logic                          clk,
	input  logic                          arst_n,
	dssp_cmd_if.sink                      cmd,
	dssp_rsp_if.source                    rsp,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [dssp_pkg::ADDR_W-1:0]   paddr,
	input  logic [dssp_pkg::DATA_W-1:0]   pwdata,
	output logic [dssp_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);

	dssp_pkg::map_cfg_t                  map_cfg_q;
	logic [dssp_pkg::WAIT_W-1:0]         center_wait_q;
	logic [dssp_pkg::WAIT_W-1:0]         settle_wait_q;
	logic                                cfg_write;
	logic [2:0]                          reg_index;

	logic                                push;
	dssp_pkg::item_t                     push_item;
	logic                                pop;
	logic                                head_valid;
	dssp_pkg::item_t                     head_item;
	logic [dssp_pkg::QUEUE_CNT_W-1:0]    queue_count;

	assign pready    = 1'b1;
	assign reg_index = paddr[4:2];
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_cfg_q.x_min <= dssp_pkg::MIN_OFFSET_RST;
			map_cfg_q.x_max <= dssp_pkg::MAX_OFFSET_RST;
			map_cfg_q.y_min <= dssp_pkg::MIN_OFFSET_RST;
			map_cfg_q.y_max <= dssp_pkg::MAX_OFFSET_RST;
			center_wait_q   <= dssp_pkg::WAIT_TICKS_RST;
			settle_wait_q   <= dssp_pkg::WAIT_TICKS_RST;
		end else if (cfg_write) begin
			unique case (reg_index)
				dssp_pkg::REG_X_MIN:       map_cfg_q.x_min <= pwdata[dssp_pkg::OFFSET_W-1:0];
				dssp_pkg::REG_X_MAX:       map_cfg_q.x_max <= pwdata[dssp_pkg::OFFSET_W-1:0];
				dssp_pkg::REG_Y_MIN:       map_cfg_q.y_min <= pwdata[dssp_pkg::OFFSET_W-1:0];
				dssp_pkg::REG_Y_MAX:       map_cfg_q.y_max <= pwdata[dssp_pkg::OFFSET_W-1:0];
				dssp_pkg::REG_CENTER_WAIT: center_wait_q   <= pwdata[dssp_pkg::WAIT_W-1:0];
				dssp_pkg::REG_SETTLE_WAIT: settle_wait_q   <= pwdata[dssp_pkg::WAIT_W-1:0];
				default: ;
			endcase
		end
	end

	// the centering wait is not used by the timer, which resets to WAIT_TICKS_RST; it is kept for readback
	always_comb begin
		unique case (reg_index)
			dssp_pkg::REG_X_MIN:       prdata = dssp_pkg::DATA_W'(map_cfg_q.x_min);
			dssp_pkg::REG_X_MAX:       prdata = dssp_pkg::DATA_W'(map_cfg_q.x_max);
			dssp_pkg::REG_Y_MIN:       prdata = dssp_pkg::DATA_W'(map_cfg_q.y_min);
			dssp_pkg::REG_Y_MAX:       prdata = dssp_pkg::DATA_W'(map_cfg_q.y_max);
			dssp_pkg::REG_CENTER_WAIT: prdata = dssp_pkg::DATA_W'(center_wait_q);
			dssp_pkg::REG_SETTLE_WAIT: prdata = dssp_pkg::DATA_W'(settle_wait_q);
			default:                   prdata = '0;
		endcase
	end

	dssp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg         (map_cfg_q),
		.queue_count (queue_count),
		.push        (push),
		.push_item   (push_item)
	);

	dssp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item),
		.count      (queue_count)
	);

	dssp_back #(
		.STEP_LIMIT (STEP_LIMIT)
	) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.head_valid        (head_valid),
		.head_item         (head_item),
		.settle_wait_ticks (settle_wait_q),
		.pop               (pop),
		.rsp               (rsp)
	);

endmodule

### tb/servo_slew_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_slew_checker
// Watches the request, result and register channels of the servo positioner.
// It keeps its own copy of the axis state, works out the result of every
// accepted request and compares each result field by field, in order.
// ----------------------------------------------------------------------------
module servo_slew_checker
	import dssp_pkg::*;
#(
	parameter int STEP_LIMIT = 30
) (
	input  logic               clk,
	input  logic               arst_n,
	dssp_cmd_if                cmd,
	dssp_rsp_if                rsp,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output int                 fail_count,
	output int                 outstanding
);

	localparam int  TENTHS      = 10;
	localparam int  MAX_REPORTS = 40;
	localparam int  HALF_SCALE  = 16;

	typedef struct packed {
		logic [COMPARE_W-1:0] compare_x;
		logic [COMPARE_W-1:0] compare_y;
		logic                 motion_done;
		logic                 settled;
		logic [PHASE_W-1:0]   phase;
	} servo_result_t;

	// register copies
	logic [OFFSET_W-1:0] x_min, x_max, y_min, y_max;
	logic [WAIT_W-1:0]   center_wait, settle_wait;

	// axis and phase state, positions and offsets in tenth-microseconds
	int                  pos_x, pos_y;
	int                  rem_x, rem_y;
	logic [PHASE_W-1:0]  phase_now;
	logic [WAIT_W-1:0]   wait_cnt;
	logic                wait_on;

	servo_result_t       pwm_results_due[$];
	int                  result_index;

	initial begin
		fail_count  = 0;
		outstanding = 0;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("%0t result %0d: %s is %0d, expected %0d", $time, result_index, what,
				got, want);
	endtask

	// clamp the goal to one full fraction and map it between the two offsets
	function automatic int goal_to_target(input logic signed [GOAL_W-1:0] goal,
		input logic [OFFSET_W-1:0] lo, input logic [OFFSET_W-1:0] hi);
		longint v;
		longint total;
		v = longint'(goal);
		if (v < 0)
			v = 0;
		if (v > longint'(FRAC_ONE))
			v = longint'(FRAC_ONE);
		total = (longint'(BASE_PULSE_US) + longint'(lo)) * TENTHS * longint'(FRAC_ONE)
			+ v * (longint'(hi) - longint'(lo)) * TENTHS;
		if (total < 0)
			total = 0;
		return int'(total >>> HALF_SCALE);
	endfunction

	function automatic bit slew(inout int pos, inout int rem);
		int d;
		if (rem == 0)
			return 1'b0;
		d = rem;
		if (d > STEP_LIMIT)
			d = STEP_LIMIT;
		if (d < -STEP_LIMIT)
			d = -STEP_LIMIT;
		rem -= d;
		pos += d;
		return 1'b1;
	endfunction

	function automatic servo_result_t advance_servo(input logic mode,
		input logic signed [GOAL_W-1:0] gx, input logic signed [GOAL_W-1:0] gy);
		servo_result_t r;
		bit moved_x, moved_y;
		r.motion_done = 1'b0;
		r.settled     = 1'b0;
		if (mode == MODE_MOVE) begin
			rem_x = goal_to_target(gx, x_min, x_max) - pos_x;
			rem_y = goal_to_target(gy, y_min, y_max) - pos_y;
			if (phase_now == PHASE_CODE_IDLE)
				phase_now = PHASE_CODE_MOVING;
			else if (phase_now == PHASE_CODE_MOVING)
				wait_on = 1'b0;
		end else begin
			// the wait timer is served before the axes move
			if (wait_on) begin
				if (wait_cnt <= 1) begin
					wait_on  = 1'b0;
					wait_cnt = '0;
					if (phase_now == PHASE_CODE_MOVING)
						r.settled = 1'b1;
					phase_now = PHASE_CODE_IDLE;
				end else begin
					wait_cnt = wait_cnt - 1'b1;
				end
			end
			moved_x = slew(pos_x, rem_x);
			moved_y = slew(pos_y, rem_y);
			if ((moved_x || moved_y) && rem_x == 0 && rem_y == 0) begin
				r.motion_done = 1'b1;
				if (phase_now == PHASE_CODE_MOVING) begin
					wait_cnt = settle_wait;
					wait_on  = 1'b1;
				end
			end
		end
		r.compare_x = COMPARE_W'(pos_x / TENTHS);
		r.compare_y = COMPARE_W'(pos_y / TENTHS);
		r.phase     = phase_now;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		servo_result_t got;
		servo_result_t want;
		if (!arst_n) begin
			x_min       = MIN_OFFSET_RST;
			x_max       = MAX_OFFSET_RST;
			y_min       = MIN_OFFSET_RST;
			y_max       = MAX_OFFSET_RST;
			center_wait = WAIT_TICKS_RST;
			settle_wait = WAIT_TICKS_RST;
			pos_x       = int'(CENTER_POS);
			pos_y       = int'(CENTER_POS);
			rem_x       = 0;
			rem_y       = 0;
			phase_now   = PHASE_CODE_CENTER;
			wait_cnt    = WAIT_TICKS_RST;
			wait_on     = 1'b1;
			pwm_results_due.delete();
			outstanding  = 0;
			result_index = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_W-1:2])
					REG_X_MIN:       x_min = pwdata[OFFSET_W-1:0];
					REG_X_MAX:       x_max = pwdata[OFFSET_W-1:0];
					REG_Y_MIN:       y_min = pwdata[OFFSET_W-1:0];
					REG_Y_MAX:       y_max = pwdata[OFFSET_W-1:0];
					REG_CENTER_WAIT: center_wait = pwdata[WAIT_W-1:0];
					REG_SETTLE_WAIT: settle_wait = pwdata[WAIT_W-1:0];
					default: ;
				endcase
			end
			if (rsp.valid && rsp.ready) begin
				got.compare_x   = rsp.compare_x;
				got.compare_y   = rsp.compare_y;
				got.motion_done = rsp.motion_done;
				got.settled     = rsp.settled;
				got.phase       = rsp.phase;
				if (pwm_results_due.size() == 0) begin
					report_mismatch("result with no request pending", got.compare_x, -1);
				end else begin
					want = pwm_results_due.pop_front();
					outstanding--;
					if (got.compare_x !== want.compare_x)
						report_mismatch("compare_x", got.compare_x, want.compare_x);
					if (got.compare_y !== want.compare_y)
						report_mismatch("compare_y", got.compare_y, want.compare_y);
					if (got.motion_done !== want.motion_done)
						report_mismatch("motion_done", got.motion_done, want.motion_done);
					if (got.settled !== want.settled)
						report_mismatch("settled", got.settled, want.settled);
					if (got.phase !== want.phase)
						report_mismatch("phase", got.phase, want.phase);
				end
				result_index++;
			end
			if (cmd.valid && cmd.ready) begin
				pwm_results_due.push_back(advance_servo(cmd.mode, cmd.goal_x, cmd.goal_y));
				outstanding++;
			end
		end
	end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the dual servo slew positioner: directed moves and
// ticks through centering, then random phases over several register settings
// with idling on both channels, a long result hold-off and drain pauses.
// ----------------------------------------------------------------------------
module tb_top;
	import dssp_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES    = 300;
	localparam int TAIL_CYCLES    = 16;
	localparam int MOVE_PCT       = 7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic              psel, penable, pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	int fail_count;
	int outstanding;
	int quiet_cycles = 0;
	int send_idle_pct = 0;
	int rcv_stall_pct = 0;
	bit hold_on = 1'b0;
	bit hold_done = 1'b0;
	int hold_count = 0;

	logic signed [GOAL_W-1:0] last_gx = '0;
	logic signed [GOAL_W-1:0] last_gy = '0;

	dssp_cmd_if cmd_ch();
	dssp_rsp_if rsp_ch();

	dual_servo_slew_positioner dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	servo_slew_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd_ch),
		.rsp         (rsp_ch),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// result side: random stalls, plus one long hold-off when asked
	always @(negedge clk) begin
		if (hold_on && !hold_done) begin
			rsp_ch.ready <= 1'b0;
			hold_count++;
			if (hold_count >= HOLD_CYCLES)
				hold_done = 1'b1;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= rcv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic offer(input logic mode, input logic signed [GOAL_W-1:0] gx,
		input logic signed [GOAL_W-1:0] gy);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_ch.valid  <= 1'b1;
		cmd_ch.mode   <= mode;
		cmd_ch.goal_x <= gx;
		cmd_ch.goal_y <= gy;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		cmd_ch.valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] index, input int value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {index, 2'b00};
		pwdata  <= DATA_W'(value);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic write_settings(input int xmin, input int xmax, input int ymin,
		input int ymax, input int center, input int settle);
		drain();
		write_reg(REG_X_MIN, xmin);
		write_reg(REG_X_MAX, xmax);
		write_reg(REG_Y_MIN, ymin);
		write_reg(REG_Y_MAX, ymax);
		write_reg(REG_CENTER_WAIT, center);
		write_reg(REG_SETTLE_WAIT, settle);
	endtask

	// mostly short hops from the last goal so that motions finish and settle
	function automatic logic signed [GOAL_W-1:0] pick_goal(input logic signed [GOAL_W-1:0] prev);
		int sel;
		int g;
		sel = $urandom_range(99);
		if (sel < 55)
			g = int'(prev) + int'($urandom_range(4000)) - 2000;
		else if (sel < 70)
			g = int'($urandom_range(65536));
		else if (sel < 80)
			g = int'(prev);
		else if (sel < 92)
			g = int'($urandom);
		else begin
			case ($urandom_range(3))
				0:       g = 0;
				1:       g = int'(FRAC_ONE);
				2:       g = -131072;
				default: g = 131071;
			endcase
		end
		return GOAL_W'(g);
	endfunction

	task automatic random_items(input int count);
		int n;
		logic signed [GOAL_W-1:0] gx, gy;
		for (n = 0; n < count; n++) begin
			if ($urandom_range(99) < MOVE_PCT) begin
				if ($urandom_range(99) >= 8) begin
					gx = pick_goal(last_gx);
					gy = pick_goal(last_gy);
				end else begin
					gx = last_gx;
					gy = last_gy;
				end
				last_gx = gx;
				last_gy = gy;
				offer(MODE_MOVE, gx, gy);
			end else begin
				offer(MODE_TICK, GOAL_W'($urandom), GOAL_W'($urandom));
			end
		end
	endtask

	task automatic set_idling(input int send_pct, input int rcv_pct);
		send_idle_pct = send_pct;
		rcv_stall_pct = rcv_pct;
	endtask

	initial begin
		cmd_ch.valid  = 1'b0;
		cmd_ch.mode   = MODE_TICK;
		cmd_ch.goal_x = '0;
		cmd_ch.goal_y = '0;
		rsp_ch.ready  = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		set_idling(0, 0);
		write_settings(0, 1600, 0, 1600, 150, 150);

		// still centering: goal at center leaves nothing to do
		offer(MODE_TICK, '0, '0);
		offer(MODE_MOVE, 18'sd32768, 18'sd32768);
		offer(MODE_TICK, -18'sd1, -18'sd1);
		// small hop, x done in one step, y in two
		offer(MODE_MOVE, 18'sd32868, 18'sd32568);
		offer(MODE_TICK, '0, '0);
		offer(MODE_TICK, '0, '0);
		offer(MODE_TICK, '0, '0);
		// clamping at both ends of the fraction
		offer(MODE_MOVE, '0, '0);
		offer(MODE_TICK, '0, '0);
		offer(MODE_MOVE, -18'sd131072, -18'sd1);
		offer(MODE_TICK, 18'sd131071, -18'sd131072);
		offer(MODE_MOVE, 18'sd131071, 18'sd65537);
		offer(MODE_TICK, '0, '0);
		offer(MODE_MOVE, 18'sd65536, 18'sd65535);
		offer(MODE_TICK, '0, '0);
		offer(MODE_TICK, '0, '0);
		offer(MODE_MOVE, 18'sd1, 18'sd65536);
		offer(MODE_TICK, '0, '0);
		last_gx = 18'sd1;
		last_gy = 18'sd65536;

		// runs past the end of centering
		random_items(250);

		// full ranges, y runs downward, zero settle wait
		write_settings(0, 2047, 2047, 0, 1023, 0);
		set_idling(65, 0);
		random_items(250);

		// narrow ranges, results held off for a long stretch first
		write_settings(800, 830, 400, 380, 1, 1);
		set_idling(0, 65);
		hold_on = 1'b1;
		random_items(250);

		// zero spans, sender pauses until all results are back midway
		write_settings(0, 0, 1600, 1600, 0, 1023);
		set_idling(21, 21);
		random_items(100);
		drain();
		random_items(100);

		write_settings(100, 1700, 1500, 200, 150, 20);
		set_idling(0, 0);
		random_items(250);

		write_settings(2047, 1000, 1000, 2047, 512, 3);
		set_idling(21, 21);
		random_items(200);

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		@(negedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

### dual_servo_slew_positioner.f
design/dssp_pkg.sv
design/dssp_ifs.sv
design/dssp_front.sv
design/dssp_queue.sv
design/dssp_back.sv
design/dual_servo_slew_positioner.sv
tb/servo_slew_checker.sv
tb/tb_top.sv
